/* sv/pcl_pkg.sv */
// Package for the PI current loop: configuration record, sequencer states,
// register indexes and fixed constants. No dependencies.
`default_nettype none

package pcl_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Q24 unity
    localparam logic signed [MUL_P_W-1:0] Q_ONE = MUL_P_W'(1) <<< 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INIT_REF  = 3'd0,
        REG_PROP_GAIN = 3'd1,
        REG_INTEG_GAIN = 3'd2,
        REG_INTEG_LIM = 3'd3,
        REG_FLIP_PER  = 3'd4,
        REG_RUN_LEN   = 3'd5,
        REG_PWM_WRAP  = 3'd6
    } t_reg_idx;

    localparam logic signed [15:0] RST_INIT_REF   = 16'sd200;
    localparam logic [23:0]        RST_PROP_GAIN  = 24'd16777;
    localparam logic [23:0]        RST_INTEG_GAIN = 24'd168;
    localparam logic [14:0]        RST_INTEG_LIM  = 15'd5000;
    localparam logic [15:0]        RST_FLIP_PER   = 16'd14;
    localparam logic [15:0]        RST_RUN_LEN    = 16'd784;
    localparam logic [15:0]        RST_PWM_WRAP   = 16'd6249;

    typedef struct packed {
        logic signed [15:0] initial_reference;
        logic [23:0]        prop_gain;
        logic [23:0]        integ_gain;
        logic [14:0]        integral_limit;
        logic [15:0]        flip_period;
        logic [15:0]        run_length;
        logic [15:0]        pwm_wrap;
    } t_cfg;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ERR  = 8'b0000_0010,
        ST_MP   = 8'b0000_0100,
        ST_MI   = 8'b0000_1000,
        ST_ACC  = 8'b0001_0000,
        ST_SAT  = 8'b0010_0000,
        ST_SCL  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } t_state;

endpackage

`default_nettype wire

/* sv/pcl_mul.sv */
// Shared signed multiplier with registered product, used for both gain
// products and the PWM level scaling. Uses pcl_pkg widths.
`default_nettype none

module pcl_mul (
    input  wire logic                                 i_clk,
    input  wire logic signed [pcl_pkg::MUL_A_W-1:0]   i_a,
    input  wire logic signed [pcl_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [pcl_pkg::MUL_P_W-1:0]        o_p
);

    logic signed [pcl_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= pcl_pkg::MUL_P_W'(i_a) * pcl_pkg::MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* sv/pcl_cfg.sv */
// Configuration register file of the PI current loop, write-only port.
// Depends on pcl_pkg for the register indexes and reset values.
`default_nettype none

module pcl_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [pcl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output pcl_pkg::t_cfg                          o_cfg
);

    pcl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_reference <= pcl_pkg::RST_INIT_REF;
            r_cfg.prop_gain         <= pcl_pkg::RST_PROP_GAIN;
            r_cfg.integ_gain        <= pcl_pkg::RST_INTEG_GAIN;
            r_cfg.integral_limit    <= pcl_pkg::RST_INTEG_LIM;
            r_cfg.flip_period       <= pcl_pkg::RST_FLIP_PER;
            r_cfg.run_length        <= pcl_pkg::RST_RUN_LEN;
            r_cfg.pwm_wrap          <= pcl_pkg::RST_PWM_WRAP;
        end else if (i_cfg_we) begin
            unique case (pcl_pkg::t_reg_idx'(i_cfg_idx))
                pcl_pkg::REG_INIT_REF:   r_cfg.initial_reference <= i_cfg_data[15:0];
                pcl_pkg::REG_PROP_GAIN:  r_cfg.prop_gain <= i_cfg_data[23:0];
                pcl_pkg::REG_INTEG_GAIN: r_cfg.integ_gain <= i_cfg_data[23:0];
                pcl_pkg::REG_INTEG_LIM:  r_cfg.integral_limit <= i_cfg_data[14:0];
                pcl_pkg::REG_FLIP_PER:   r_cfg.flip_period <= i_cfg_data[15:0];
                pcl_pkg::REG_RUN_LEN:    r_cfg.run_length <= i_cfg_data[15:0];
                pcl_pkg::REG_PWM_WRAP:   r_cfg.pwm_wrap <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* sv/pi_current_loop_hbridge_pwm.sv */
// PI current loop: a running tick is taken in ST_IDLE, passes through ST_ERR, ST_MP, ST_MI,
// ST_ACC, ST_SAT, ST_SCL and ST_OUT, and its result beat is then offered; no new tick is
// taken before the sequencer is back in ST_IDLE. Three passes go through the single 26x18
// multiplier (proportional term, integral term, level scaling). Start beats and ticks while
// stopped give no beat. The output register frees the input side while a beat waits.
// Synchronous active-low reset: stopped, reference = initial_reference, counts cleared.
`default_nettype none

module pi_current_loop_hbridge_pwm (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [pcl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [pcl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [15:0]                       i_s_tdata,  // [15:0] measured_current
    input  wire logic                              i_s_tuser,  // [0] kind
    // result stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [47:0]                            o_m_tdata,  // [15:0] level_a,
                                                               // [31:16] level_b,
                                                               // [47:32] reference_used
    output logic                                   o_m_tlast   // run_done
);

    localparam int AW = pcl_pkg::MUL_A_W;
    localparam int BW = pcl_pkg::MUL_B_W;
    localparam int PW = pcl_pkg::MUL_P_W;

    pcl_pkg::t_cfg   cfg;
    pcl_pkg::t_state r_state;

    logic               r_running;
    logic signed [15:0] r_ref;
    logic signed [15:0] r_esum;
    logic [15:0]        r_flip;
    logic [15:0]        r_samp;
    logic signed [15:0] r_meas;
    logic signed [15:0] r_used;
    logic signed [16:0] r_err;
    logic signed [15:0] r_sum;
    logic               r_done;
    logic signed [PW-1:0] r_acc;
    logic [24:0]        r_mag;
    logic               r_pos;
    logic               r_neg;

    logic        r_ovalid;
    logic [15:0] r_la;
    logic [15:0] r_lb;
    logic [15:0] r_oref;
    logic        r_olast;

    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    logic signed [16:0] err;
    logic signed [17:0] sum_raw;
    logic signed [17:0] lim;
    logic signed [15:0] sum_clamp;
    logic [15:0]        samp_next;
    logic [15:0]        flip_inc;
    logic               flip_hit;
    logic               brake;
    logic signed [15:0] ref_neg;
    logic signed [PW-1:0] acc_abs;
    logic [15:0]        scaled;
    logic               beat_in;
    logic               out_free;

    pcl_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pcl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Operand select; the scaling operands are the default so the product
    // holds steady while the result waits in ST_OUT.
    always_comb begin
        unique case (r_state)
            pcl_pkg::ST_MP: begin
                mul_a = AW'({1'b0, cfg.prop_gain});
                mul_b = BW'(r_err);
            end
            pcl_pkg::ST_MI: begin
                mul_a = AW'({1'b0, cfg.integ_gain});
                mul_b = BW'(r_sum);
            end
            default: begin
                mul_a = AW'({1'b0, r_mag});
                mul_b = BW'({1'b0, cfg.pwm_wrap});
            end
        endcase
    end

    // Error, clamped integral and run bookkeeping
    always_comb begin
        err     = 17'(r_ref) - 17'(r_meas);
        sum_raw = 18'(r_esum) + 18'(err);
        lim     = 18'({1'b0, cfg.integral_limit});
        priority if (sum_raw > lim)
            sum_clamp = 16'(lim);
        else if (sum_raw < -lim)
            sum_clamp = 16'(-lim);
        else
            sum_clamp = 16'(sum_raw);
        samp_next = (r_samp < cfg.run_length) ? r_samp + 16'd1 : r_samp;
        flip_inc  = r_flip + 16'd1;
        flip_hit  = flip_inc >= cfg.flip_period;
        brake     = samp_next >= cfg.run_length;
        ref_neg   = (r_ref == 16'sh8000) ? 16'sh7fff : -r_ref;
    end

    assign acc_abs  = r_acc[PW-1] ? -r_acc : r_acc;
    assign scaled   = mul_p[39:24];
    assign beat_in  = i_s_tvalid && o_s_tready;
    assign out_free = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pcl_pkg::ST_IDLE;
            r_running <= 1'b0;
            r_ref     <= pcl_pkg::RST_INIT_REF;
            r_esum    <= '0;
            r_flip    <= '0;
            r_samp    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_state == pcl_pkg::ST_OUT && out_free)
                r_ovalid <= 1'b1;
            else if (i_m_tready)
                r_ovalid <= 1'b0;
            unique case (r_state)
                pcl_pkg::ST_IDLE: begin
                    if (beat_in) begin
                        if (!i_s_tuser) begin
                            r_running <= 1'b1;
                            r_ref     <= cfg.initial_reference;
                            r_samp    <= '0;
                            r_esum    <= '0;
                        end else if (r_running) begin
                            r_state <= pcl_pkg::ST_ERR;
                        end
                    end
                end
                pcl_pkg::ST_ERR: begin
                    r_samp <= samp_next;
                    r_flip <= flip_hit ? 16'd0 : flip_inc;
                    if (flip_hit)
                        r_ref <= ref_neg;
                    r_esum <= (flip_hit || brake) ? 16'sd0 : sum_clamp;
                    if (brake)
                        r_running <= 1'b0;
                    r_state <= pcl_pkg::ST_MP;
                end
                pcl_pkg::ST_MP:  r_state <= pcl_pkg::ST_MI;
                pcl_pkg::ST_MI:  r_state <= pcl_pkg::ST_ACC;
                pcl_pkg::ST_ACC: r_state <= pcl_pkg::ST_SAT;
                pcl_pkg::ST_SAT: r_state <= pcl_pkg::ST_SCL;
                pcl_pkg::ST_SCL: r_state <= pcl_pkg::ST_OUT;
                pcl_pkg::ST_OUT: begin
                    if (out_free)
                        r_state <= pcl_pkg::ST_IDLE;
                end
                default: r_state <= pcl_pkg::ST_IDLE;
            endcase
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == pcl_pkg::ST_IDLE && beat_in) begin
            r_meas <= i_s_tdata;
            r_used <= r_ref;
        end
        if (r_state == pcl_pkg::ST_ERR) begin
            r_err  <= err;
            r_sum  <= sum_clamp;
            r_done <= brake;
        end
        if (r_state == pcl_pkg::ST_MI)
            r_acc <= mul_p;
        if (r_state == pcl_pkg::ST_ACC)
            r_acc <= r_acc + mul_p;
        if (r_state == pcl_pkg::ST_SAT) begin
            priority if (r_acc > pcl_pkg::Q_ONE) begin
                r_mag <= 25'h100_0000;
                r_pos <= 1'b1;
                r_neg <= 1'b0;
            end else if (r_acc < -pcl_pkg::Q_ONE) begin
                r_mag <= 25'h100_0000;
                r_pos <= 1'b0;
                r_neg <= 1'b1;
            end else begin
                r_mag <= acc_abs[24:0];
                r_pos <= (r_acc > 0);
                r_neg <= r_acc[PW-1];
            end
        end
        if (r_state == pcl_pkg::ST_OUT && out_free) begin
            r_la    <= (r_done || !r_pos) ? cfg.pwm_wrap : scaled;
            r_lb    <= (r_done || !r_neg) ? cfg.pwm_wrap : scaled;
            r_oref  <= r_used;
            r_olast <= r_done;
        end
    end

    assign o_s_tready = (r_state == pcl_pkg::ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_oref, r_lb, r_la};
    assign o_m_tlast  = r_olast;

endmodule

`default_nettype wire

/* sv/pcl_chk.sv */
// Port-level checks for the PI current loop, bound to the top level.
// Depends only on the top level's handshake and result ports.
`default_nettype none

module pcl_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_s_tvalid,
    input wire logic                              o_s_tready,
    input wire logic                              i_s_tuser,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [47:0]                       o_m_tdata,
    input wire logic                              o_m_tlast
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("result beat changed while stalled");

    // after a start beat the input is ready again in the next cycle
    a_start_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser |=> o_s_tready)
        else $error("start beat did not free the input");

    // a new result only comes out of a busy period
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared without a busy period");

    // braking beat drives both levels to the same top value
    a_brake_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[15:0] == o_m_tdata[31:16])
        else $error("braking beat with unequal levels");

endmodule

bind pi_current_loop_hbridge_pwm pcl_chk u_pcl_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

/* tb/pcl_tb_pkg.sv */
// Bench-side types for the PI current loop: item kinds on the input stream
// and the record of one result beat. No dependencies.
package pcl_tb_pkg;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_TICK  = 1'b1
    } item_kind_e;

    typedef struct packed {
        logic [15:0]        level_a;
        logic [15:0]        level_b;
        logic signed [15:0] ref_used;
        logic               run_done;
    } bridge_levels_t;

endpackage

/* tb/pcl_checker.sv */
// Scoreboard for the PI current loop: tracks register writes, predicts the
// bridge levels of every accepted running tick and compares result beats in order.
// Depends on pcl_pkg and pcl_tb_pkg.
module pcl_checker
    import pcl_pkg::*;
    import pcl_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [15:0]           i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [47:0]           i_m_tdata,
    input  logic                  i_m_tlast,
    output int                    o_fail_count,
    output int                    o_pending
);

    t_cfg               cfg;
    bit                 running;
    logic signed [15:0] loop_ref;
    longint             integ;
    logic [15:0]        flip_cnt;
    logic [15:0]        sample_cnt;
    bridge_levels_t     expected_levels[$];
    int                 fails = 0;

    function automatic bit predict_levels(input item_kind_e kind,
                                          input logic signed [15:0] meas,
                                          output bridge_levels_t res);
        longint      err;
        longint      lim;
        longint      duty;
        longint      mag;
        logic [15:0] lvl;
        res = '0;
        if (kind == KIND_START) begin
            running    = 1'b1;
            loop_ref   = cfg.initial_reference;
            sample_cnt = '0;
            integ      = 0;
            return 1'b0;
        end
        if (!running) return 1'b0;

        res.ref_used = loop_ref;
        err   = longint'(loop_ref) - longint'(meas);
        lim   = longint'(cfg.integral_limit);
        integ = integ + err;
        if (integ > lim) integ = lim;
        else if (integ < -lim) integ = -lim;

        duty = longint'(cfg.prop_gain) * err + longint'(cfg.integ_gain) * integ;
        if (duty > longint'(Q_ONE)) duty = longint'(Q_ONE);
        if (duty < -longint'(Q_ONE)) duty = -longint'(Q_ONE);
        mag = (duty < 0) ? -duty : duty;
        lvl = 16'((mag * longint'(cfg.pwm_wrap)) >>> 24);

        // the driven side gets the scaled level, the other one sits at wrap
        res.level_a = (duty > 0) ? lvl : cfg.pwm_wrap;
        res.level_b = (duty < 0) ? lvl : cfg.pwm_wrap;

        if (sample_cnt < cfg.run_length) sample_cnt = sample_cnt + 16'd1;

        flip_cnt = flip_cnt + 16'd1;
        if (flip_cnt >= cfg.flip_period) begin
            flip_cnt = '0;
            loop_ref = (loop_ref == 16'sh8000) ? 16'sh7FFF : -loop_ref;
            integ    = 0;
        end

        if (sample_cnt >= cfg.run_length) begin
            running      = 1'b0;
            res.level_a  = cfg.pwm_wrap;
            res.level_b  = cfg.pwm_wrap;
            integ        = 0;
            res.run_done = 1'b1;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        bridge_levels_t exp_beat;
        bridge_levels_t act_beat;
        bridge_levels_t new_beat;
        if (!i_rst_n) begin
            cfg.initial_reference = RST_INIT_REF;
            cfg.prop_gain         = RST_PROP_GAIN;
            cfg.integ_gain        = RST_INTEG_GAIN;
            cfg.integral_limit    = RST_INTEG_LIM;
            cfg.flip_period       = RST_FLIP_PER;
            cfg.run_length        = RST_RUN_LEN;
            cfg.pwm_wrap          = RST_PWM_WRAP;
            running    = 1'b0;
            loop_ref   = RST_INIT_REF;
            integ      = 0;
            flip_cnt   = '0;
            sample_cnt = '0;
            expected_levels.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_INIT_REF:   cfg.initial_reference = i_cfg_data[15:0];
                    REG_PROP_GAIN:  cfg.prop_gain         = i_cfg_data;
                    REG_INTEG_GAIN: cfg.integ_gain        = i_cfg_data;
                    REG_INTEG_LIM:  cfg.integral_limit    = i_cfg_data[14:0];
                    REG_FLIP_PER:   cfg.flip_period       = i_cfg_data[15:0];
                    REG_RUN_LEN:    cfg.run_length        = i_cfg_data[15:0];
                    REG_PWM_WRAP:   cfg.pwm_wrap          = i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // result side first, so a beat with nothing queued is never masked
            if (i_m_tvalid && i_m_tready) begin
                act_beat.level_a  = i_m_tdata[15:0];
                act_beat.level_b  = i_m_tdata[31:16];
                act_beat.ref_used = i_m_tdata[47:32];
                act_beat.run_done = i_m_tlast;
                if (expected_levels.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected beat: a=%0d b=%0d ref=%0d done=%0b",
                                 act_beat.level_a, act_beat.level_b,
                                 act_beat.ref_used, act_beat.run_done);
                end else begin
                    exp_beat = expected_levels.pop_front();
                    if (act_beat.level_a !== exp_beat.level_a ||
                        act_beat.level_b !== exp_beat.level_b ||
                        act_beat.ref_used !== exp_beat.ref_used ||
                        act_beat.run_done !== exp_beat.run_done) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp a=%0d b=%0d ref=%0d done=%0b, %s",
                                     exp_beat.level_a, exp_beat.level_b,
                                     exp_beat.ref_used, exp_beat.run_done,
                                     $sformatf("got a=%0d b=%0d ref=%0d done=%0b",
                                               act_beat.level_a, act_beat.level_b,
                                               act_beat.ref_used, act_beat.run_done));
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                if (predict_levels(item_kind_e'(i_s_tuser), i_s_tdata, new_beat))
                    expected_levels.push_back(new_beat);
            end
        end
        o_pending    <= expected_levels.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/tb.sv */
// Top of the PI current loop bench: clock, reset, register writes, input
// stimulus, receiver back-pressure and the verdict. Depends on pcl_pkg,
// pcl_tb_pkg, pcl_checker and the pi_current_loop_hbridge_pwm block.
module tb;
    import pcl_pkg::*;
    import pcl_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int ITEM_COUNT     = 700;
    localparam int SETTLE_CYCLES  = 16;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;
    logic                  m_tlast;

    int fail_count;
    int pending;
    int burst_left  = 0;
    bit no_gaps     = 1'b0;
    int hold_req    = 0;
    int idle_cycles = 0;
    int item_count  = 0;

    logic [15:0] corner_currents [10] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h00C8,
                                          16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA,
                                          16'hFF38, 16'h00C8};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pi_current_loop_hbridge_pwm dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [15:0] measured_current
        .i_s_tuser  (s_tuser),   // [0] kind
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // [15:0] level_a, [31:16] level_b, [47:32] reference_used
        .o_m_tlast  (m_tlast)    // run_done
    );

    pcl_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // one input beat; bursts of random length separated by random gaps
    task automatic send_item(input item_kind_e kind, input logic [15:0] meas);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_count++;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= meas;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // wait until every expected beat is out and the block has gone quiet
    task automatic settle();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input t_cfg c);
        t_reg_idx r;
        r = r.first();
        do begin
            cfg_we  <= 1'b1;
            cfg_idx <= r;
            case (r)
                REG_INIT_REF:   cfg_data <= {8'h00, c.initial_reference};
                REG_PROP_GAIN:  cfg_data <= c.prop_gain;
                REG_INTEG_GAIN: cfg_data <= c.integ_gain;
                REG_INTEG_LIM:  cfg_data <= CFG_DATA_W'(c.integral_limit);
                REG_FLIP_PER:   cfg_data <= CFG_DATA_W'(c.flip_period);
                REG_RUN_LEN:    cfg_data <= CFG_DATA_W'(c.run_length);
                REG_PWM_WRAP:   cfg_data <= CFG_DATA_W'(c.pwm_wrap);
                default: ;
            endcase
            @(posedge clk);
            r = r.next();
        end while (r != r.first());
        cfg_we <= 1'b0;
    endtask

    function automatic t_cfg random_config();
        t_cfg c;
        case ($urandom_range(0, 5))
            0:       c.initial_reference = 16'sh8000;
            1:       c.initial_reference = 16'sh7FFF;
            2:       c.initial_reference = 16'($urandom);
            default: c.initial_reference = 16'(int'($urandom_range(0, 1000)) - 500);
        endcase
        case ($urandom_range(0, 5))
            0:       c.prop_gain = '0;
            1:       c.prop_gain = 24'hFFFFFF;
            2:       c.prop_gain = 24'($urandom);
            default: c.prop_gain = 24'($urandom_range(0, 60000));
        endcase
        case ($urandom_range(0, 5))
            0:       c.integ_gain = '0;
            1:       c.integ_gain = 24'hFFFFFF;
            2:       c.integ_gain = 24'($urandom);
            default: c.integ_gain = 24'($urandom_range(0, 2000));
        endcase
        case ($urandom_range(0, 4))
            0:       c.integral_limit = '0;
            1:       c.integral_limit = 15'h7FFF;
            2:       c.integral_limit = 15'($urandom);
            default: c.integral_limit = 15'($urandom_range(0, 8000));
        endcase
        case ($urandom_range(0, 6))
            0:       c.flip_period = '0;
            1:       c.flip_period = 16'hFFFF;
            2:       c.flip_period = 16'd1;
            default: c.flip_period = 16'($urandom_range(2, 20));
        endcase
        case ($urandom_range(0, 6))
            0:       c.run_length = '0;
            1:       c.run_length = 16'hFFFF;
            2:       c.run_length = 16'd1;
            default: c.run_length = 16'($urandom_range(2, 50));
        endcase
        case ($urandom_range(0, 4))
            0:       c.pwm_wrap = '0;
            1:       c.pwm_wrap = 16'hFFFF;
            default: c.pwm_wrap = 16'($urandom);
        endcase
        return c;
    endfunction

    // near the reference two draws in five, so duty stays off the rails part of the time
    function automatic logic [15:0] random_current(input logic signed [15:0] center);
        case ($urandom_range(0, 4))
            0:       return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            1, 2:    return 16'($urandom);
            default: return 16'(int'(center) + int'($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    // receiver: random ready modes, plus one long hold-off on request
    initial begin
        int served;
        int mode;
        int left;
        served = 0;
        mode   = 0;
        left   = 0;
        forever begin
            @(posedge clk);
            if (hold_req != served) begin
                served = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_cfg       c;
        item_kind_e kind;
        int         run_pos;
        bit         run_known;
        bit         stopped_now;
        int         phase;
        int         phase_items;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: a tick while stopped, a run over the corner currents, then a restart
        send_item(KIND_TICK, 16'h1234);
        send_item(KIND_START, 16'h0000);
        foreach (corner_currents[i]) send_item(KIND_TICK, corner_currents[i]);
        send_item(KIND_START, 16'hFFFF);
        send_item(KIND_TICK, 16'h00C8);

        // full-scale gains, flip on every tick from the most negative reference
        settle();
        c = '{initial_reference: 16'sh8000, prop_gain: 24'hFFFFFF,
              integ_gain: 24'hFFFFFF, integral_limit: 15'h7FFF,
              flip_period: 16'd1, run_length: 16'd4, pwm_wrap: 16'hFFFF};
        write_config(c);
        send_item(KIND_START, 16'h0000);
        send_item(KIND_TICK, 16'h7FFF);
        send_item(KIND_TICK, 16'h0000);
        send_item(KIND_TICK, 16'h8000);
        send_item(KIND_TICK, 16'h1234);
        send_item(KIND_TICK, 16'h0000);

        // zero flip period, zero run length, zero wrap
        settle();
        c = '{initial_reference: 16'sh0000, prop_gain: 24'h000000,
              integ_gain: 24'h000000, integral_limit: 15'h0000,
              flip_period: 16'd0, run_length: 16'd0, pwm_wrap: 16'h0000};
        write_config(c);
        send_item(KIND_START, 16'h0000);
        send_item(KIND_TICK, 16'h0000);

        // zero error gives zero duty, then the flipped reference drives side B
        settle();
        c = '{initial_reference: 16'sd100, prop_gain: 24'd16777,
              integ_gain: 24'h000000, integral_limit: 15'h0000,
              flip_period: 16'd0, run_length: 16'd3, pwm_wrap: 16'd1000};
        write_config(c);
        send_item(KIND_START, 16'h0000);
        send_item(KIND_TICK, 16'd100);
        send_item(KIND_TICK, 16'd100);
        send_item(KIND_TICK, 16'hFF00);

        phase = 0;
        while (item_count < ITEM_COUNT) begin
            settle();
            c = random_config();
            // long run so the held-off receiver lets results pile up
            if (phase == 2)
                c.run_length = 16'hFFFF;
            write_config(c);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // sender keeps offering while the receiver holds off
                no_gaps = 1'b1;
                hold_req <= hold_req + 1;
            end
            run_known = 1'b0;
            run_pos   = 0;
            if (phase == 2 || $urandom_range(0, 3) != 0) begin
                send_item(KIND_START, 16'($urandom));
                run_known = 1'b1;
            end else begin
                // ticks into a run left over from the previous settings
                send_item(KIND_TICK, random_current(c.initial_reference));
                send_item(KIND_TICK, random_current(c.initial_reference));
            end
            phase_items = $urandom_range(20, 80);
            repeat (phase_items) begin
                stopped_now = !run_known || run_pos >= int'(c.run_length);
                if (stopped_now)
                    kind = ($urandom_range(0, 3) != 0) ? KIND_START : KIND_TICK;
                else
                    kind = ($urandom_range(0, 31) == 0) ? KIND_START : KIND_TICK;
                send_item(kind, random_current(c.initial_reference));
                if (kind == KIND_START) begin
                    run_known = 1'b1;
                    run_pos   = 0;
                end else if (!stopped_now) begin
                    run_pos++;
                end
            end
            phase++;
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
